>>> rtl/core/bpta_pkg.sv
// Package for the block peak threshold alarm unit.
// Holds widths, codes, shared types and the percent-to-full-scale helper.
// No dependencies.
package bpta_pkg;

    localparam int NUM_CHANNELS = 32;
    localparam int CHAN_AW      = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int CHAN_W       = 5;
    localparam int NUM_GROUPS   = 3;
    localparam int FULL_SCALE   = 2048;
    localparam int PERCENT      = 100;

    localparam int SAMPLE_W = 16;
    localparam int CAL_W    = 16;
    localparam int PEAK_W   = 12;
    localparam int THR_W    = 13;
    localparam int CFG_W    = 7;
    localparam int CFG_IW   = 3;

    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 40;

    // Truncating division by PERCENT as a multiply by a rounded-up reciprocal.
    // Exact for every dividend below 2**DIV_W.
    localparam int DIV_LIMIT = FULL_SCALE * PERCENT;
    localparam int DIV_W     = $clog2(DIV_LIMIT);
    localparam int DIV_SHIFT = 25;
    localparam int DIV_RECIP = ((2 ** DIV_SHIFT) + PERCENT - 1) / PERCENT;
    localparam int RECIP_W   = $clog2(DIV_RECIP + 1);
    localparam int QUOT_W    = DIV_W + RECIP_W;
    localparam int FS_SHIFT  = $clog2(FULL_SCALE);
    localparam int PCT_PW    = CFG_W + RECIP_W;

    localparam logic [CFG_W-1:0] SUPP_RESET  = '0;
    localparam logic [CFG_W-1:0] ALERT_RESET = CFG_W'(PERCENT);

    typedef enum logic [0:0] {
        OP_CALIB  = 1'b0,
        OP_SAMPLE = 1'b1
    } op_t;

    typedef enum logic [CFG_IW-1:0] {
        REG_SUPP0  = 3'd0,
        REG_SUPP1  = 3'd1,
        REG_SUPP2  = 3'd2,
        REG_ALERT0 = 3'd3,
        REG_ALERT1 = 3'd4,
        REG_ALERT2 = 3'd5
    } cfg_index_t;

    typedef enum logic [1:0] {
        ALARM_NONE = 2'd0,
        ALARM_COIL = 2'd1,
        ALARM_WALL = 2'd2
    } alarm_code_t;

    typedef logic [1:0] grp_t;

    typedef struct packed {
        logic valid;
        grp_t grp;
        logic last;
    } item_ctrl_t;

    typedef struct packed {
        alarm_code_t       alarm_code;
        logic              alarm;
        logic [PEAK_W-1:0] peak_group2;
        logic [PEAK_W-1:0] peak_group1;
        logic [PEAK_W-1:0] peak_group0;
    } result_t;

    typedef logic [NUM_GROUPS-1:0][THR_W-1:0] thr_vec_t;

    // percent * FULL_SCALE / PERCENT, truncated.
    function automatic logic [PEAK_W-1:0] pct_to_fs(input logic [CFG_W-1:0] pct);
        logic [PCT_PW-1:0] prod;
        prod = PCT_PW'(pct) * PCT_PW'(DIV_RECIP);
        return PEAK_W'(prod >> (DIV_SHIFT - FS_SHIFT));
    endfunction

    localparam logic [THR_W-1:0] THR_RESET =
        THR_W'(pct_to_fs(SUPP_RESET)) + THR_W'(pct_to_fs(ALERT_RESET));

endpackage

>>> rtl/core/block_peak_threshold_alarm_unit.sv
// Block peak threshold alarm unit: top level with stream ports and config.
// A block-end sample passes the calibration registers p1 to p5 and then the
// result register before m_tvalid shows its result. Throughput: one item per cycle;
// s_tready drops only while a block-end result waits behind an untaken output.
// Reset clears the pipeline, the running peaks and the config registers; the
// calibration RAM is not cleared and holds garbage until written.
// Depends on bpta_pkg, bpta_calib and bpta_peak.
module block_peak_threshold_alarm_unit
    import bpta_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // channel[4:0], grp[6:5], sample_value[22:7], baseline[38:23], gain[54:39]
    input  logic [S_TDATA_W-1:0] s_tdata,
    // op[0]
    input  logic [0:0]           s_tuser,
    input  logic                 s_tlast,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // peak_group0[11:0], peak_group1[23:12], peak_group2[35:24], alarm[36],
    // alarm_code[38:37]
    output logic [M_TDATA_W-1:0] m_tdata,
    input  logic                 cfg_we,
    input  logic [CFG_IW-1:0]    cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata
);

    logic [CFG_W-1:0] supp_reg  [NUM_GROUPS];
    logic [CFG_W-1:0] alert_reg [NUM_GROUPS];
    thr_vec_t         thr_reg, thr_next;

    logic             stall;
    logic             advance;
    logic             accept;
    item_ctrl_t       pipe_ctrl;
    logic [PEAK_W-1:0] pipe_mag;
    result_t          res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int g = 0; g < NUM_GROUPS; g++) begin
                supp_reg[g]  <= SUPP_RESET;
                alert_reg[g] <= ALERT_RESET;
            end
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_SUPP0:  supp_reg[0]  <= cfg_wdata;
                REG_SUPP1:  supp_reg[1]  <= cfg_wdata;
                REG_SUPP2:  supp_reg[2]  <= cfg_wdata;
                REG_ALERT0: alert_reg[0] <= cfg_wdata;
                REG_ALERT1: alert_reg[1] <= cfg_wdata;
                REG_ALERT2: alert_reg[2] <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // A group fires when peak > suppression + alert level, both in full-scale units.
    always_comb begin
        for (int g = 0; g < NUM_GROUPS; g++) begin
            thr_next[g] = THR_W'(pct_to_fs(supp_reg[g])) + THR_W'(pct_to_fs(alert_reg[g]));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int g = 0; g < NUM_GROUPS; g++) begin
                thr_reg[g] <= THR_RESET;
            end
        end else begin
            thr_reg <= thr_next;
        end
    end

    assign advance  = !stall;
    assign s_tready = advance;
    assign accept   = s_tvalid && s_tready;

    bpta_calib u_calib (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .advance       (advance),
        .accept        (accept),
        .op            (op_t'(s_tuser[0])),
        .channel       (s_tdata[4:0]),
        .grp           (s_tdata[6:5]),
        .sample_value  (s_tdata[22:7]),
        .baseline      (s_tdata[38:23]),
        .gain          (s_tdata[54:39]),
        .last_of_block (s_tlast),
        .ctrl_out      (pipe_ctrl),
        .mag_out       (pipe_mag)
    );

    bpta_peak u_peak (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl_in   (pipe_ctrl),
        .mag_in    (pipe_mag),
        .thr       (thr_reg),
        .m_tready  (m_tready),
        .stall     (stall),
        .res_valid (m_tvalid),
        .res       (res)
    );

    assign m_tdata = {1'b0, res};

`ifndef ASSERT_OFF
    a_ready_only_blocked_by_output: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input held off without a waiting result");

    a_peaks_clamped: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (res.peak_group0 <= PEAK_W'(FULL_SCALE))
                  && (res.peak_group1 <= PEAK_W'(FULL_SCALE))
                  && (res.peak_group2 <= PEAK_W'(FULL_SCALE)))
        else $error("reported peak above full scale");

    a_alarm_matches_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (res.alarm == (res.alarm_code != ALARM_NONE)))
        else $error("alarm flag disagrees with alarm code");

    a_stall_holds_pipeline: assert property (@(posedge aclk) disable iff (!aresetn)
        stall |=> (pipe_ctrl == $past(pipe_ctrl)) && m_tvalid)
        else $error("pipeline moved while stalled");
`endif

endmodule

>>> rtl/core/bpta_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module bpta_ram #(
    parameter int  WIDTH = 32,
    parameter int  DEPTH = 32,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> rtl/core/bpta_calib.sv
// Calibration store and correction pipeline: table RAM, baseline subtract,
// gain multiply, magnitude with clamp, and division by 100.
// Depends on bpta_pkg and bpta_ram.
module bpta_calib
    import bpta_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                advance,
    input  logic                accept,
    input  op_t                 op,
    input  logic [CHAN_W-1:0]   channel,
    input  grp_t                grp,
    input  logic [SAMPLE_W-1:0] sample_value,
    input  logic [CAL_W-1:0]    baseline,
    input  logic [CAL_W-1:0]    gain,
    input  logic                last_of_block,
    output item_ctrl_t          ctrl_out,
    output logic [PEAK_W-1:0]   mag_out
);

    logic                 chan_ok;
    logic                 ram_we;
    logic                 ram_re;
    logic [CHAN_AW-1:0]   ram_addr;
    logic [2*CAL_W-1:0]   ram_rdata;

    item_ctrl_t           p1_ctrl_reg, p2_ctrl_reg, p3_ctrl_reg, p4_ctrl_reg, p5_ctrl_reg;
    item_ctrl_t           p1_ctrl_next;
    logic [SAMPLE_W-1:0]  p1_sample_reg;
    logic                 p1_chan_ok_reg;

    logic signed [17:0]   p2_diff_reg, p2_diff_next;
    logic signed [15:0]   p2_gain_reg, p2_gain_next;
    logic signed [33:0]   p3_prod_reg, p3_prod_next;
    logic [33:0]          prod_abs;
    logic [DIV_W-1:0]     p4_x_reg, p4_x_next;
    logic                 p4_sat_reg, p4_sat_next;
    logic [QUOT_W-1:0]    quot;
    logic [PEAK_W-1:0]    p5_mag_reg, p5_mag_next;

    assign chan_ok  = 32'(channel) < 32'(NUM_CHANNELS);
    assign ram_addr = CHAN_AW'(channel);
    assign ram_we   = accept && (op == OP_CALIB) && chan_ok;
    assign ram_re   = accept && (op == OP_SAMPLE);

    // Gain in the upper half, baseline in the lower half.
    bpta_ram #(
        .WIDTH (2 * CAL_W),
        .DEPTH (NUM_CHANNELS)
    ) u_cal_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_addr),
        .wdata ({gain, baseline}),
        .re    (ram_re),
        .raddr (ram_addr),
        .rdata (ram_rdata)
    );

    always_comb begin
        p1_ctrl_next.valid = ram_re;
        p1_ctrl_next.grp   = grp;
        p1_ctrl_next.last  = last_of_block;

        p2_diff_next = $signed({2'b00, p1_sample_reg})
                     - $signed({{2{ram_rdata[CAL_W-1]}}, ram_rdata[CAL_W-1:0]});
        // A channel beyond the table corrects to zero.
        p2_gain_next = p1_chan_ok_reg ? $signed(ram_rdata[2*CAL_W-1:CAL_W]) : '0;

        p3_prod_next = 34'(p2_diff_reg) * 34'(p2_gain_reg);

        // Truncation toward zero: divide the magnitude, the sign is dropped anyway.
        prod_abs    = p3_prod_reg[33] ? 34'(-p3_prod_reg) : 34'(p3_prod_reg);
        p4_sat_next = prod_abs >= 34'(DIV_LIMIT);
        p4_x_next   = prod_abs[DIV_W-1:0];

        quot        = QUOT_W'(p4_x_reg) * QUOT_W'(DIV_RECIP);
        p5_mag_next = p4_sat_reg ? PEAK_W'(FULL_SCALE) : PEAK_W'(quot >> DIV_SHIFT);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_ctrl_reg <= '0;
            p2_ctrl_reg <= '0;
            p3_ctrl_reg <= '0;
            p4_ctrl_reg <= '0;
            p5_ctrl_reg <= '0;
        end else if (advance) begin
            p1_ctrl_reg <= p1_ctrl_next;
            p2_ctrl_reg <= p1_ctrl_reg;
            p3_ctrl_reg <= p2_ctrl_reg;
            p4_ctrl_reg <= p3_ctrl_reg;
            p5_ctrl_reg <= p4_ctrl_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            p1_sample_reg  <= sample_value;
            p1_chan_ok_reg <= chan_ok;
            p2_diff_reg    <= p2_diff_next;
            p2_gain_reg    <= p2_gain_next;
            p3_prod_reg    <= p3_prod_next;
            p4_x_reg       <= p4_x_next;
            p4_sat_reg     <= p4_sat_next;
            p5_mag_reg     <= p5_mag_next;
        end
    end

    assign ctrl_out = p5_ctrl_reg;
    assign mag_out  = p5_mag_reg;

endmodule

>>> rtl/core/bpta_peak.sv
// Running peaks per group, end-of-block evaluation and the result register.
// Depends on bpta_pkg.
module bpta_peak
    import bpta_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  item_ctrl_t        ctrl_in,
    input  logic [PEAK_W-1:0] mag_in,
    input  thr_vec_t          thr,
    input  logic              m_tready,
    output logic              stall,
    output logic              res_valid,
    output result_t           res
);

    logic [PEAK_W-1:0] peak_reg  [NUM_GROUPS];
    logic [PEAK_W-1:0] peak_next [NUM_GROUPS];
    logic [NUM_GROUPS-1:0] fire;
    logic              coil, wall;
    logic              advance;
    logic              emit;
    logic              out_valid_reg;
    result_t           out_reg, out_next;

    // Only a block end meeting an untaken result holds the pipeline.
    assign stall   = ctrl_in.valid && ctrl_in.last && out_valid_reg && !m_tready;
    assign advance = !stall;
    assign emit    = advance && ctrl_in.valid && ctrl_in.last;

    always_comb begin
        for (int g = 0; g < NUM_GROUPS; g++) begin
            peak_next[g] = peak_reg[g];
            if (ctrl_in.valid && (ctrl_in.grp == grp_t'(g)) && (mag_in > peak_reg[g])) begin
                peak_next[g] = mag_in;
            end
            fire[g] = THR_W'(peak_next[g]) > thr[g];
        end
        coil = fire[0] || fire[1];
        wall = fire[2];

        out_next.peak_group0 = peak_next[0];
        out_next.peak_group1 = peak_next[1];
        out_next.peak_group2 = peak_next[2];
        out_next.alarm       = coil || wall;
        if (wall) begin
            out_next.alarm_code = ALARM_WALL;
        end else if (coil) begin
            out_next.alarm_code = ALARM_COIL;
        end else begin
            out_next.alarm_code = ALARM_NONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int g = 0; g < NUM_GROUPS; g++) begin
                peak_reg[g] <= '0;
            end
            out_valid_reg <= 1'b0;
        end else begin
            if (advance && ctrl_in.valid) begin
                for (int g = 0; g < NUM_GROUPS; g++) begin
                    peak_reg[g] <= ctrl_in.last ? '0 : peak_next[g];
                end
            end
            if (emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            out_reg <= out_next;
        end
    end

    assign res_valid = out_valid_reg;
    assign res       = out_reg;

endmodule

>>> tb/bpta_alarm_checker.sv
// Checker for the block peak threshold alarm unit: watches the input, output
// and register-write ports, predicts each block report and compares it.
// Depends on bpta_pkg.
module bpta_alarm_checker
    import bpta_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    // channel[4:0], grp[6:5], sample_value[22:7], baseline[38:23], gain[54:39]
    input  logic [S_TDATA_W-1:0] s_tdata,
    // op[0]
    input  logic [0:0]           s_tuser,
    input  logic                 s_tlast,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    // peak_group0[11:0], peak_group1[23:12], peak_group2[35:24], alarm[36],
    // alarm_code[38:37]
    input  logic [M_TDATA_W-1:0] m_tdata,
    input  logic                 cfg_we,
    input  logic [CFG_IW-1:0]    cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    output int                   fail_count,
    output int                   reports_pending,
    output int                   reports_seen,
    output int                   alarms_seen
);

    localparam int MAX_PRINTED = 40;

    logic signed [CAL_W-1:0] baseline_mem [NUM_CHANNELS];
    logic signed [CAL_W-1:0] gain_mem     [NUM_CHANNELS];
    logic [PEAK_W-1:0]       group_peak   [NUM_GROUPS];
    logic [CFG_W-1:0]        supp_pct     [NUM_GROUPS];
    logic [CFG_W-1:0]        alert_pct    [NUM_GROUPS];
    result_t                 block_reports_q [$];
    int                      mismatches = 0;
    int                      checked    = 0;
    int                      alarm_hits = 0;

    assign fail_count   = mismatches;
    assign reports_seen = checked;
    assign alarms_seen  = alarm_hits;

    task automatic report_mismatch(input string msg);
        if (mismatches < MAX_PRINTED)
            $display("[%0t] report %0d: %s", $time, checked, msg);
        mismatches++;
    endtask

    // The product is formed in 64 bits so that no wrap can hide an error.
    function automatic logic [PEAK_W-1:0] corrected_magnitude(
        input logic [CHAN_W-1:0] ch, input logic [SAMPLE_W-1:0] raw);
        longint y;
        y = 0;
        if (ch < NUM_CHANNELS)
            y = (longint'(raw) - longint'(baseline_mem[ch])) * longint'(gain_mem[ch])
                / PERCENT;
        if (y < 0)
            y = -y;
        if (y > FULL_SCALE)
            y = FULL_SCALE;
        return PEAK_W'(y);
    endfunction

    function automatic bit group_over_level(input int g);
        int margin;
        int level;
        margin = int'(group_peak[g]) - int'(supp_pct[g]) * FULL_SCALE / PERCENT;
        level  = int'(alert_pct[g]) * FULL_SCALE / PERCENT;
        return margin > level;
    endfunction

    task automatic store_level(input logic [CFG_IW-1:0] idx, input logic [CFG_W-1:0] value);
        case (idx)
            REG_SUPP0:  supp_pct[0]  = value;
            REG_SUPP1:  supp_pct[1]  = value;
            REG_SUPP2:  supp_pct[2]  = value;
            REG_ALERT0: alert_pct[0] = value;
            REG_ALERT1: alert_pct[1] = value;
            REG_ALERT2: alert_pct[2] = value;
            default: ;
        endcase
    endtask

    task automatic take_item(input logic [S_TDATA_W-1:0] d, input logic [0:0] u,
                             input logic last);
        logic [CHAN_W-1:0]   ch;
        grp_t                g;
        logic [PEAK_W-1:0]   mag;
        result_t             rep;
        bit                  coil;
        bit                  wall;
        ch = d[4:0];
        g  = d[6:5];
        if (u[0] == OP_CALIB) begin
            if (ch < NUM_CHANNELS) begin
                baseline_mem[ch] = d[38:23];
                gain_mem[ch]     = d[54:39];
            end
            return;
        end
        // A sample tagged with group three touches no peak but may still end a block.
        if (g < NUM_GROUPS) begin
            mag = corrected_magnitude(ch, d[22:7]);
            if (mag > group_peak[g])
                group_peak[g] = mag;
        end
        if (!last)
            return;
        coil = group_over_level(0) || group_over_level(1);
        wall = group_over_level(2);
        rep.peak_group0 = group_peak[0];
        rep.peak_group1 = group_peak[1];
        rep.peak_group2 = group_peak[2];
        rep.alarm       = coil || wall;
        rep.alarm_code  = wall ? ALARM_WALL : (coil ? ALARM_COIL : ALARM_NONE);
        block_reports_q.push_back(rep);
        for (int i = 0; i < NUM_GROUPS; i++)
            group_peak[i] = '0;
    endtask

    task automatic compare_report(input result_t got);
        result_t want;
        if (block_reports_q.size() == 0) begin
            report_mismatch("report arrived with no block end outstanding");
            return;
        end
        want = block_reports_q.pop_front();
        if (got.peak_group0 !== want.peak_group0)
            report_mismatch($sformatf("peak_group0 is %0d, expected %0d",
                                      got.peak_group0, want.peak_group0));
        if (got.peak_group1 !== want.peak_group1)
            report_mismatch($sformatf("peak_group1 is %0d, expected %0d",
                                      got.peak_group1, want.peak_group1));
        if (got.peak_group2 !== want.peak_group2)
            report_mismatch($sformatf("peak_group2 is %0d, expected %0d",
                                      got.peak_group2, want.peak_group2));
        if (got.alarm !== want.alarm)
            report_mismatch($sformatf("alarm is %b, expected %b", got.alarm, want.alarm));
        if (got.alarm_code !== want.alarm_code)
            report_mismatch($sformatf("alarm_code is %0d, expected %0d",
                                      got.alarm_code, want.alarm_code));
        if (want.alarm)
            alarm_hits++;
        checked++;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_GROUPS; i++) begin
                group_peak[i] = '0;
                supp_pct[i]   = SUPP_RESET;
                alert_pct[i]  = ALERT_RESET;
            end
            block_reports_q.delete();
        end else begin
            if (cfg_we)
                store_level(cfg_index, cfg_wdata);
            if (m_tvalid && m_tready)
                compare_report(result_t'(m_tdata[$bits(result_t)-1:0]));
            if (s_tvalid && s_tready)
                take_item(s_tdata, s_tuser, s_tlast);
        end
        reports_pending <= block_reports_q.size();
    end

endmodule

>>> tb/tb_block_peak_threshold_alarm_unit.sv
// Testbench top for the block peak threshold alarm unit: clock, reset,
// directed and random sensor traffic, register phases and the verdict.
// Depends on bpta_pkg, the unit and bpta_alarm_checker.
module tb_block_peak_threshold_alarm_unit;
    import bpta_pkg::*;

    localparam int RESET_CYCLES  = 12;
    localparam int MAX_WAIT      = 16;
    localparam int HOLD_CYCLES   = 400;
    // Margin for the unit's pipeline and result register to drain after the last report.
    localparam int DRAIN_CYCLES  = 8;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 122;
    // Watchdog limit on the length of the whole run.
    localparam int LIMIT_CYCLES  = 250000;
    localparam logic [CFG_IW-1:0] REG_SPARE6 = 3'd6;
    localparam logic [CFG_IW-1:0] REG_SPARE7 = 3'd7;

    typedef struct {
        op_t                     op;
        logic [CHAN_W-1:0]       ch;
        grp_t                    grp;
        logic [SAMPLE_W-1:0]     raw;
        logic signed [CAL_W-1:0] base;
        logic signed [CAL_W-1:0] gain;
        logic                    last;
    } sensor_item_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    // channel[4:0], grp[6:5], sample_value[22:7], baseline[38:23], gain[54:39]
    logic [S_TDATA_W-1:0] s_tdata;
    // op[0]
    logic [0:0]           s_tuser;
    logic                 s_tlast;
    logic                 m_tvalid;
    logic                 m_tready;
    // peak_group0[11:0], peak_group1[23:12], peak_group2[35:24], alarm[36],
    // alarm_code[38:37]
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 cfg_we;
    logic [CFG_IW-1:0]    cfg_index;
    logic [CFG_W-1:0]     cfg_wdata;

    int                      fail_count;
    int                      reports_pending;
    int                      reports_seen;
    int                      alarms_seen;
    int                      items_sent = 0;
    int                      hold_requests = 0;
    int unsigned             cycles;
    bit                      quiet = 1'b0;
    bit                      cal_written [NUM_CHANNELS];
    logic signed [CAL_W-1:0] cal_base    [NUM_CHANNELS];

    block_peak_threshold_alarm_unit u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    bpta_alarm_checker u_alarm_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .s_tlast         (s_tlast),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .fail_count      (fail_count),
        .reports_pending (reports_pending),
        .reports_seen    (reports_seen),
        .alarms_seen     (alarms_seen)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic sensor_item_t calib_item(input int ch, input int base,
                                                input int gain, input bit last);
        sensor_item_t it;
        it.op   = OP_CALIB;
        it.ch   = CHAN_W'(ch);
        it.grp  = grp_t'($urandom_range(0, 3));
        it.raw  = SAMPLE_W'($urandom);
        it.base = CAL_W'(base);
        it.gain = CAL_W'(gain);
        it.last = last;
        return it;
    endfunction

    function automatic sensor_item_t sample_item(input int ch, input int grp,
                                                 input int raw, input bit last);
        sensor_item_t it;
        it.op   = OP_SAMPLE;
        it.ch   = CHAN_W'(ch);
        it.grp  = grp_t'(grp);
        it.raw  = SAMPLE_W'(raw);
        it.base = CAL_W'($urandom);
        it.gain = CAL_W'($urandom);
        it.last = last;
        return it;
    endfunction

    // Mostly samples on calibrated channels, placed near the baseline so that
    // the peaks spread across the alarm levels instead of all clamping.
    function automatic sensor_item_t random_item(input int end_odds);
        int ch;
        int v;
        if ($urandom_range(0, 99) < 15) begin
            ch = $urandom_range(0, NUM_CHANNELS - 1);
            if ($urandom_range(0, 3) == 0)
                return calib_item(ch, $urandom, $urandom, $urandom_range(0, 1));
            return calib_item(ch, $urandom_range(0, 30000),
                              int'($urandom_range(0, 400)) - 200, $urandom_range(0, 1));
        end
        do
            ch = $urandom_range(0, NUM_CHANNELS - 1);
        while (!cal_written[ch]);
        if ($urandom_range(0, 3) == 0) begin
            v = $urandom_range(0, 65535);
        end else begin
            v = int'(cal_base[ch]) + int'($urandom_range(0, 3000)) - 1500;
            if (v < 0)
                v = 0;
            if (v > 65535)
                v = 65535;
        end
        return sample_item(ch, ($urandom_range(0, 11) == 0) ? 3 : $urandom_range(0, 2),
                           v, $urandom_range(1, end_odds) == 1);
    endfunction

    task automatic send_item(input sensor_item_t it);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.op;
        s_tlast  <= it.last;
        s_tdata  <= S_TDATA_W'({it.gain, it.base, it.raw, it.grp, it.ch});
        do @(posedge aclk); while (!s_tready);
        if (it.op == OP_CALIB) begin
            cal_written[it.ch] = 1'b1;
            cal_base[it.ch]    = it.base;
        end
        items_sent++;
    endtask

    // The pending count is registered, hence the edge before the loop.
    task automatic wait_for_reports();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (reports_pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic put_reg(input logic [CFG_IW-1:0] idx, input int value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= CFG_W'(value);
        @(posedge aclk);
    endtask

    task automatic program_levels(input int s0, s1, s2, a0, a1, a2, input bit spare);
        put_reg(REG_SUPP0, s0);
        put_reg(REG_SUPP1, s1);
        put_reg(REG_SUPP2, s2);
        put_reg(REG_ALERT0, a0);
        put_reg(REG_ALERT1, a1);
        put_reg(REG_ALERT2, a2);
        // Indexes past the last register must leave every level alone.
        if (spare) begin
            put_reg(REG_SPARE6, $urandom_range(0, 127));
            put_reg(REG_SPARE7, $urandom_range(0, 127));
        end
        cfg_we <= 1'b0;
    endtask

    // Result side: a random stall per report, plus one long hold on request.
    initial begin
        int holds_done;
        int wait_cycles;
        holds_done = 0;
        m_tready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_requests != holds_done) begin
                holds_done = hold_requests;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            wait_cycles = quiet ? 0 : $urandom_range(0, MAX_WAIT);
            if (wait_cycles > 0) begin
                m_tready <= 1'b0;
                repeat (wait_cycles) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    initial begin
        cycles = 0;
        while (cycles < LIMIT_CYCLES) begin
            @(posedge aclk);
            cycles++;
        end
        $display("timed out after %0d cycles, %0d reports outstanding",
                 cycles, reports_pending);
        $display("status: fail");
        $finish;
    end

    initial begin
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= OP_CALIB;
        s_tlast   <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= REG_SUPP0;
        cfg_wdata <= '0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Calibration at the extremes; an end mark on a calibration write
        // must not produce a report.
        send_item(calib_item(0, 0, 100, 1'b1));
        send_item(calib_item(31, -32768, 32767, 1'b0));
        send_item(calib_item(1, 32767, -32768, 1'b0));
        send_item(calib_item(2, 1000, 0, 1'b1));
        send_item(calib_item(3, 0, -7, 1'b0));
        // Peaks just below, at and above full scale; group three ends the block.
        send_item(sample_item(0, 0, 2047, 1'b0));
        send_item(sample_item(0, 1, 2048, 1'b0));
        send_item(sample_item(0, 2, 2049, 1'b0));
        send_item(sample_item(2, 3, 65535, 1'b1));
        // Large products of both signs, one beyond the 32-bit signed range.
        send_item(sample_item(31, 0, 65535, 1'b0));
        send_item(sample_item(1, 1, 0, 1'b0));
        send_item(sample_item(1, 2, 65535, 1'b1));
        // A block of group three alone reports all-zero peaks.
        send_item(sample_item(0, 3, 0, 1'b1));
        // The quotient -10.43 has to truncate to -10.
        send_item(sample_item(3, 0, 149, 1'b1));
        wait_for_reports();

        // Group 0 fires above 1228, group 1 above 1024, the wall above 0.
        program_levels(10, 0, 0, 50, 50, 0, 1'b0);
        send_item(sample_item(0, 0, 1228, 1'b1));
        send_item(sample_item(0, 1, 1025, 1'b1));
        send_item(sample_item(0, 2, 1, 1'b1));
        send_item(sample_item(0, 0, 1229, 1'b0));
        send_item(sample_item(0, 2, 3, 1'b1));

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            wait_for_reports();
            case (ph)
                0: program_levels(0, 0, 0, 0, 0, 0, 1'b0);
                2: program_levels(127, 127, 127, 0, 0, 0, 1'b0);
                4: program_levels(0, 0, 0, 127, 127, 127, 1'b0);
                5: program_levels(0, 50, 100, 100, 0, 50, 1'b1);
                6: program_levels($urandom_range(0, 127), $urandom_range(0, 127),
                                  $urandom_range(0, 127), $urandom_range(0, 127),
                                  $urandom_range(0, 127), $urandom_range(0, 127), 1'b1);
                default: begin
                    program_levels($urandom_range(0, 30), $urandom_range(0, 30),
                                   $urandom_range(0, 30), $urandom_range(10, 90),
                                   $urandom_range(10, 90), $urandom_range(10, 90), ph == 1);
                end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                quiet = (ph % 3 == 1) && (n < PHASE_ITEMS / 2);
                if (ph == 3 && n == 20) begin
                    // Keep sending dense blocks while results are held back,
                    // so that reports pile up and the input stalls.
                    quiet = 1'b1;
                    hold_requests++;
                    repeat (60) send_item(random_item(3));
                    quiet = 1'b0;
                end
                if (ph == 5 && n == PHASE_ITEMS / 2)
                    wait_for_reports();
                send_item(random_item(8));
            end
        end
        quiet = 1'b0;
        wait_for_reports();

        $display("run covered %0d input transfers and %0d block reports, %0d of them alarms",
                 items_sent, reports_seen, alarms_seen);
        $display("levels ranged from 0 to 127 per group; the result side was held for %0d cycles",
                 HOLD_CYCLES);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

>>> files.f
rtl/core/bpta_pkg.sv
rtl/core/bpta_ram.sv
rtl/core/bpta_calib.sv
rtl/core/bpta_peak.sv
rtl/core/block_peak_threshold_alarm_unit.sv
tb/bpta_alarm_checker.sv
tb/tb_block_peak_threshold_alarm_unit.sv
